// ----- rtl/sspq_pkg.sv -----
// Package for the stable sorted priority queue.
// Holds the sequencer state type, entry type, opcode and status codes.
// No dependencies.
package sspq_pkg;

    localparam int PRIO_W   = 32;
    localparam int HANDLE_W = 9;
    localparam int LEN_W    = 9;
    localparam int STAT_W   = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [PRIO_W-1:0]   prio;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_CMP  = 5'b00100,
        S_WR   = 5'b01000,
        S_POP  = 5'b10000
    } t_state;

endpackage

// ----- rtl/stable_sorted_priority_queue_top.sv -----
// Stable sorted minimum priority queue, top level.
// A pop reads the entry at the head and returns it. A push shifts every held entry with a
// priority strictly greater than the new one up by a slot, from the tail down; the first
// compare that finds an entry not greater moves nothing, and the new entry goes behind it.
// The entries sit in a circular buffer in one memory with a single write port and a
// registered read port, and the sequencer moves one entry a step, each step a read and
// then a compare-and-write through the one shared comparator. Pop on an empty queue
// and push into a full queue answer from the idle state. The receiver cannot stall: each
// result word shows on the o_ result ports for exactly one cycle, with o_strobe high.
// Depends on sspq_pkg.
module stable_sorted_priority_queue_top
    import sspq_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_opcode,
    input  logic [PRIO_W-1:0]   i_priority_req,
    input  logic [HANDLE_W-1:0] i_payload_handle,
    output logic                o_strobe,
    output logic [HANDLE_W-1:0] o_out_handle,
    output logic [PRIO_W-1:0]   o_out_priority,
    output logic [LEN_W-1:0]    o_length,
    output logic [STAT_W-1:0]   o_status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL = CW'(CAPACITY);

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [AW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_left, n_left;
    t_entry        r_new, n_new;

    logic                r_strobe, n_strobe;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic [PRIO_W-1:0]   r_prio, n_prio;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [STAT_W-1:0]   r_stat, n_stat;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_entry        w_wdata;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_prev;
    logic          w_accept;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] a);
        return (a == LAST) ? '0 : a + 1'b1;
    endfunction

    assign w_prev   = (r_pos == '0) ? LAST : r_pos - 1'b1;
    assign w_raddr  = (r_state == S_RD) ? w_prev : r_head;
    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_pos    = r_pos;
        n_count  = r_count;
        n_left   = r_left;
        n_new    = r_new;
        n_strobe = 1'b0;
        n_handle = '0;
        n_prio   = '0;
        n_len    = r_len;
        n_stat   = ST_OK;
        w_we     = 1'b0;
        w_waddr  = r_pos;
        w_wdata  = r_new;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_opcode == OP_POP) begin
                        if (r_count == '0) begin
                            n_strobe = 1'b1;
                            n_len    = '0;
                            n_stat   = ST_EMPTY;
                        end else begin
                            n_state = S_POP;
                        end
                    end else if (r_count == FULL) begin
                        n_strobe = 1'b1;
                        n_len    = LEN_W'(r_count);
                        n_stat   = ST_FULL;
                    end else begin
                        n_new.prio   = i_priority_req;
                        n_new.handle = i_payload_handle;
                        n_pos        = r_tail;
                        n_left       = r_count;
                        n_state      = (r_count == '0) ? S_WR : S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_rdata.prio > r_new.prio) begin
                    w_we    = 1'b1;
                    w_wdata = r_rdata;
                    n_pos   = w_prev;
                    n_left  = r_left - 1'b1;
                    n_state = (r_left == CW'(1)) ? S_WR : S_RD;
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                w_we     = 1'b1;
                n_count  = r_count + 1'b1;
                n_tail   = f_next(r_tail);
                n_strobe = 1'b1;
                n_len    = LEN_W'(n_count);
                n_state  = S_IDLE;
            end
            S_POP: begin
                n_head   = f_next(r_head);
                n_count  = r_count - 1'b1;
                n_strobe = 1'b1;
                n_handle = r_rdata.handle;
                n_prio   = r_rdata.prio;
                n_len    = LEN_W'(n_count);
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_left   <= n_left;
        r_new    <= n_new;
        r_handle <= n_handle;
        r_prio   <= n_prio;
        r_len    <= n_len;
        r_stat   <= n_stat;
    end

    assign o_strobe       = r_strobe;
    assign o_out_handle   = r_handle;
    assign o_out_priority = r_prio;
    assign o_length       = r_len;
    assign o_status       = r_stat;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for stable_sorted_priority_queue_top: directed and random push/pop words,
// checked against a sorted-queue scoreboard class. Depends on sspq_pkg and the top RTL.
module testbench;
    import sspq_pkg::*;

    localparam int CAPACITY = 256;
    localparam int ITEMS    = 1400;
    localparam int LIMIT    = 4_000_000;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [PRIO_W-1:0]   prio;
        logic [LEN_W-1:0]    len;
        logic [STAT_W-1:0]   status;
    } t_word;

    class pq_scoreboard #(int DEPTH = 256);
        t_entry slots[DEPTH];
        int     held;
        int     errors;
        t_word  pending[$];

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        function void note_word(logic op, logic [PRIO_W-1:0] p, logic [HANDLE_W-1:0] h);
            t_word w;
            int    pos;
            w = '0;
            if (op == OP_POP) begin
                if (held == 0) begin
                    w.status = ST_EMPTY;
                end else begin
                    w.handle = slots[0].handle;
                    w.prio   = slots[0].prio;
                    for (int i = 1; i < held; i++) slots[i-1] = slots[i];
                    held--;
                    w.len    = LEN_W'(held);
                    w.status = ST_OK;
                end
            end else if (held >= DEPTH) begin
                w.len    = LEN_W'(held);
                w.status = ST_FULL;
            end else begin
                pos = held;
                for (int i = 0; i < held; i++) begin
                    if (slots[i].prio > p) begin
                        pos = i;
                        break;
                    end
                end
                for (int i = held; i > pos; i--) slots[i] = slots[i-1];
                slots[pos].prio   = p;
                slots[pos].handle = h;
                held++;
                w.len    = LEN_W'(held);
                w.status = ST_OK;
            end
            pending.push_back(w);
        endfunction

        function void check_word(t_word got);
            t_word want;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.handle !== want.handle) begin
                $error("out_handle: expected %0d, actual %0d", want.handle, got.handle);
                errors++;
            end
            if (got.prio !== want.prio) begin
                $error("out_priority: expected %0h, actual %0h", want.prio, got.prio);
                errors++;
            end
            if (got.len !== want.len) begin
                $error("length: expected %0d, actual %0d", want.len, got.len);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_opcode;
    logic [PRIO_W-1:0]   i_priority_req;
    logic [HANDLE_W-1:0] i_payload_handle;
    logic                o_strobe;
    logic [HANDLE_W-1:0] o_out_handle;
    logic [PRIO_W-1:0]   o_out_priority;
    logic [LEN_W-1:0]    o_length;
    logic [STAT_W-1:0]   o_status;

    pq_scoreboard #(CAPACITY) sb;
    int                       sent;
    int                       cycles;
    bit                       calm;

    stable_sorted_priority_queue_top #(.CAPACITY(CAPACITY)) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_priority_req   (i_priority_req),
        .i_payload_handle (i_payload_handle),
        .o_strobe         (o_strobe),
        .o_out_handle     (o_out_handle),
        .o_out_priority   (o_out_priority),
        .o_length         (o_length),
        .o_status         (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                sb.check_word('{handle: o_out_handle, prio: o_out_priority,
                                len: o_length, status: o_status});
            end
            if (start && !busy) begin
                sb.note_word(i_opcode, i_priority_req, i_payload_handle);
            end
        end
    end

    function automatic logic [PRIO_W-1:0] pick_priority(int mode);
        case (mode)
            1: return PRIO_W'($urandom_range(0, 3));
            2: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return 32'h7FFF_FFFF;
                    default: return 32'h8000_0000;
                endcase
            end
            default: return PRIO_W'($urandom);
        endcase
    endfunction

    task automatic send_word(logic op, logic [PRIO_W-1:0] p, logic [HANDLE_W-1:0] h);
        while (!calm && $urandom_range(0, 99) < 9) begin
            start            <= 1'b0;
            i_opcode         <= 1'($urandom);
            i_priority_req   <= PRIO_W'($urandom);
            i_payload_handle <= HANDLE_W'($urandom);
            @(posedge i_clk);
        end
        start            <= 1'b1;
        i_opcode         <= op;
        i_priority_req   <= p;
        i_payload_handle <= h;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic random_mix(int bias, int mode);
        repeat ($urandom_range(20, 80)) begin
            if ($urandom_range(0, 99) < bias) begin
                send_word(OP_PUSH, pick_priority(mode), HANDLE_W'($urandom));
            end else begin
                send_word(OP_POP, PRIO_W'($urandom), HANDLE_W'($urandom));
            end
        end
    endtask

    initial begin
        int phase;
        int kind;
        int mode;
        sb               = new();
        sent             = 0;
        cycles           = 0;
        calm             = 1'b0;
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_opcode         = OP_PUSH;
        i_priority_req   = '0;
        i_payload_handle = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(OP_POP, '1, '1);
        send_word(OP_PUSH, '0, '0);
        send_word(OP_PUSH, '1, 9'h1FF);
        send_word(OP_PUSH, 32'd5, 9'h155);
        send_word(OP_PUSH, 32'd5, 9'h0AA);
        send_word(OP_PUSH, '0, 9'h1FF);
        send_word(OP_PUSH, '1, 9'h100);
        repeat (6) send_word(OP_POP, '0, '0);
        send_word(OP_POP, '0, '0);
        send_word(OP_PUSH, 32'h8000_0000, 9'h0FF);
        send_word(OP_PUSH, 32'h7FFF_FFFF, 9'h001);
        send_word(OP_PUSH, 32'hA5A5_A5A5, 9'h0AA);
        send_word(OP_PUSH, 32'h5A5A_5A5A, 9'h155);
        repeat (4) send_word(OP_POP, '1, '1);
        send_word(OP_POP, '1, '1);
        start <= 1'b0;
        wait_drained();

        phase = 0;
        while (sent < ITEMS) begin
            kind = (phase == 0) ? 0 : $urandom_range(0, 5);
            mode = $urandom_range(0, 2);
            calm = (sent >= 400 && sent < 700);
            case (kind)
                0: begin
                    while (sb.held < CAPACITY) begin
                        send_word(OP_PUSH, pick_priority(mode), HANDLE_W'($urandom));
                    end
                    repeat ($urandom_range(1, 3)) begin
                        send_word(OP_PUSH, pick_priority(mode), HANDLE_W'($urandom));
                    end
                end
                1: begin
                    while (sb.held > 0) send_word(OP_POP, PRIO_W'($urandom), '1);
                    repeat ($urandom_range(1, 3)) send_word(OP_POP, '0, HANDLE_W'($urandom));
                end
                2: random_mix(30, mode);
                3: random_mix(70, mode);
                default: random_mix(50, mode);
            endcase
            if (kind == 1 || $urandom_range(0, 3) == 0) begin
                start <= 1'b0;
                wait_drained();
            end
            phase++;
        end

        start <= 1'b0;
        wait_drained();
        repeat (600) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/sspq_pkg.sv
rtl/stable_sorted_priority_queue_top.sv
test/testbench.sv
